// ===== rtl/ascii_response_frame_checker_top_macros.svh =====
// Assertion macros shared by the frame checker RTL.
// Expects clock and reset to be visible where a macro is used.
`ifndef ASCII_RESPONSE_FRAME_CHECKER_TOP_MACROS_SVH
`define ASCII_RESPONSE_FRAME_CHECKER_TOP_MACROS_SVH

// same-cycle implication
`define ARFC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("arfc: same-cycle check failed");

// next-cycle implication
`define ARFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("arfc: next-cycle check failed");

`endif

// ===== rtl/arfc_pkg.sv =====
// Types and constants of the ASCII response frame checker.
// No dependencies; used by the front, back and top level.
package arfc_pkg;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_N     = 8'h4E;

   localparam logic [2:0] FC_ACK      = 3'd0;
   localparam logic [2:0] FC_NACK     = 3'd1;
   localparam logic [2:0] FC_OTHER    = 3'd2;
   localparam logic [2:0] FC_NO_SEP   = 3'd3;
   localparam logic [2:0] FC_MISMATCH = 3'd4;
   localparam logic [2:0] FC_TOO_LONG = 3'd5;

   localparam int VF_NEG_BIT   = 0;
   localparam int VF_DIGIT_BIT = 1;
   localparam int VF_BAD_BIT   = 2;

   localparam logic [32:0] MAG_LIMIT = 33'h0_8000_0000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       is_cr;
      logic       is_ws;
      logic       is_space;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_dec;
      logic       is_sign;
      logic       is_minus;
   } byte_info_type;

endpackage

// ===== rtl/arfc_if.sv =====
// Valid/ready channel interfaces of the frame checker.
// Request carries one received byte a beat; response carries one line result a beat.
interface arfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface arfc_rsp_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  frame_code;
   logic        [7:0]  computed_sum;
   logic signed [31:0] data_value;
   logic               data_valid;
   modport source (output valid, output frame_code, output computed_sum,
                   output data_value, output data_valid, input ready);
   modport sink (input valid, input frame_code, input computed_sum,
                 input data_value, input data_valid, output ready);
endinterface

// ===== rtl/ascii_response_frame_checker_top.sv =====
// Path: a carriage return accepted on the request channel is first stored in the queue, then
// registered as a result in the back end, whose register drives the response beat.
// Throughput: one byte a cycle unless the back end holds, set by the single line-state update
// per byte. A two-beat queue separates byte intake from line tracking; while a result
// waits on the response channel the back end holds and the queue takes up to two more bytes.
// Reset is synchronous and active high: it empties the queue, clears the line state and drops
// the response valid.
module ascii_response_frame_checker_top #(
   parameter int MAX_LINE = 256
) (
   input logic        clock,
   input logic        reset,
   arfc_req_if.sink   req_chan,
   arfc_rsp_if.source rsp_chan
);
   import arfc_pkg::*;

   byte_info_type q_info;
   logic          q_valid;
   logic          q_ready;

   arfc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_info   (q_info),
      .q_valid  (q_valid),
      .q_ready  (q_ready)
   );

   arfc_back #(
      .MAX_LINE (MAX_LINE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_info   (q_info),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/arfc_front.sv =====
// Front end: accepts request beats, classifies each byte and queues it.
// Depends on arfc_pkg and arfc_req_if.
module arfc_front (
   input  logic                   clock,
   input  logic                   reset,
   arfc_req_if.sink               req_chan,
   output arfc_pkg::byte_info_type q_info,
   output logic                   q_valid,
   input  logic                   q_ready
);
   import arfc_pkg::*;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;

   byte_info_type              info_in;
   byte_info_type              q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]        wr_ptr_ff;
   logic [QUEUE_AW-1:0]        rd_ptr_ff;
   logic [QUEUE_CW-1:0]        count_ff;
   logic                       push;
   logic                       pop;
   logic [7:0]                 b;

   assign b = req_chan.rx_byte;

   always_comb begin
      info_in          = '0;
      info_in.rx_byte  = b;
      info_in.is_cr    = (b == CH_CR);
      info_in.is_space = (b == CH_SPACE);
      info_in.is_ws    = ((b >= CH_TAB) && (b <= CH_FF)) || (b == CH_SPACE);
      info_in.is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
      info_in.is_minus = (b == CH_MINUS);
      if ((b >= CH_0) && (b <= CH_9)) begin
         info_in.is_dec  = 1'b1;
         info_in.is_hex  = 1'b1;
         info_in.hex_val = b[3:0];
      end else if (((b >= CH_UA) && (b <= CH_UF)) || ((b >= CH_LA) && (b <= CH_LF))) begin
         info_in.is_hex  = 1'b1;
         info_in.hex_val = b[3:0] + 4'd9;
      end
   end

   assign req_chan.ready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign q_valid        = (count_ff != '0);
   assign q_info         = q_mem_ff[rd_ptr_ff];
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= info_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/arfc_back.sv =====
// Back end: tracks line state per byte; a result per non-blank or overlong line.
// Depends on arfc_pkg, arfc_rsp_if and the assertion macro header.
`include "ascii_response_frame_checker_top_macros.svh"

module arfc_back #(
   parameter int MAX_LINE = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  arfc_pkg::byte_info_type q_info,
   input  logic                    q_valid,
   output logic                    q_ready,
   arfc_rsp_if.source              rsp_chan
);
   import arfc_pkg::*;

   localparam int LEN_W = $clog2(MAX_LINE + 2);

   logic [LEN_W-1:0] line_length_ff, line_length_in;
   logic [7:0]       running_sum_ff, running_sum_in;
   logic [7:0]       sum_at_space_ff, sum_at_space_in;
   logic             space_seen_ff, space_seen_in;
   logic [7:0]       tok_value_ff, tok_value_in;
   logic [1:0]       tok_chars_ff, tok_chars_in;
   logic             tok_hex_ok_ff, tok_hex_ok_in;
   logic [3:0]       pending_ws_ff, pending_ws_in;
   logic [7:0]       first_char_ff, first_char_in;
   logic [1:0]       token_index_ff, token_index_in;
   logic [32:0]      value_acc_ff, value_acc_in;
   logic [2:0]       value_flags_ff, value_flags_in;
   logic             started_ff, started_in;
   logic             in_word_ff, in_word_in;
   logic             tent_valid_ff, tent_valid_in;
   logic [7:0]       tent_sum_ff, tent_sum_in;
   logic             tent_two_ff, tent_two_in;
   logic             body_two_ff, body_two_in;

   logic               out_valid_ff;
   logic [2:0]         out_code_ff;
   logic [7:0]         out_sum_ff;
   logic signed [31:0] out_value_ff;
   logic               out_dvalid_ff;

   logic        in_ready;
   logic        take;
   logic        emit;
   logic        too_long;
   logic        word_start;
   logic        neg;
   logic [2:0]  res_code;
   logic [7:0]  res_sum;
   logic [31:0] res_value;
   logic        res_dvalid;
   logic [4:0]  char_sum;
   logic [35:0] acc_cand;
   logic [32:0] acc_lim;

   assign in_ready = !out_valid_ff || rsp_chan.ready;
   assign q_ready  = in_ready;
   assign take     = q_valid && in_ready;
   assign too_long = (line_length_ff > LEN_W'(MAX_LINE));
   assign word_start = !in_word_ff;

   always_comb begin
      res_code   = FC_OTHER;
      res_sum    = '0;
      res_value  = '0;
      res_dvalid = 1'b0;
      neg        = value_flags_ff[VF_NEG_BIT];
      acc_lim    = neg ? MAG_LIMIT : MAG_LIMIT - 33'd1;
      if (too_long) begin
         res_code = FC_TOO_LONG;
      end else if (!space_seen_ff) begin
         res_code = FC_NO_SEP;
      end else begin
         res_sum = sum_at_space_ff;
         if ((tok_chars_ff != 2'd2) || !tok_hex_ok_ff || (tok_value_ff != sum_at_space_ff)) begin
            res_code = FC_MISMATCH;
         end else if (first_char_ff == CH_A) begin
            res_code = FC_ACK;
            if (body_two_ff && value_flags_ff[VF_DIGIT_BIT] && !value_flags_ff[VF_BAD_BIT]
                && (value_acc_ff <= acc_lim)) begin
               res_value  = neg ? (32'd0 - value_acc_ff[31:0]) : value_acc_ff[31:0];
               res_dvalid = 1'b1;
            end
         end else if (first_char_ff == CH_N) begin
            res_code = FC_NACK;
         end
      end
   end

   always_comb begin
      line_length_in  = line_length_ff;
      running_sum_in  = running_sum_ff;
      sum_at_space_in = sum_at_space_ff;
      space_seen_in   = space_seen_ff;
      tok_value_in    = tok_value_ff;
      tok_chars_in    = tok_chars_ff;
      tok_hex_ok_in   = tok_hex_ok_ff;
      pending_ws_in   = pending_ws_ff;
      first_char_in   = first_char_ff;
      token_index_in  = token_index_ff;
      value_acc_in    = value_acc_ff;
      value_flags_in  = value_flags_ff;
      started_in      = started_ff;
      in_word_in      = in_word_ff;
      tent_valid_in   = tent_valid_ff;
      tent_sum_in     = tent_sum_ff;
      tent_two_in     = tent_two_ff;
      body_two_in     = body_two_ff;
      emit            = 1'b0;
      char_sum        = '0;
      acc_cand        = '0;
      if (take) begin
         if (q_info.is_cr) begin
            emit            = too_long || started_ff;
            line_length_in  = '0;
            running_sum_in  = '0;
            sum_at_space_in = '0;
            space_seen_in   = 1'b0;
            tok_value_in    = '0;
            tok_chars_in    = '0;
            tok_hex_ok_in   = 1'b1;
            pending_ws_in   = '0;
            first_char_in   = '0;
            token_index_in  = '0;
            value_acc_in    = '0;
            value_flags_in  = '0;
            started_in      = 1'b0;
            in_word_in      = 1'b0;
            tent_valid_in   = 1'b0;
            tent_sum_in     = '0;
            tent_two_in     = 1'b0;
            body_two_in     = 1'b0;
         end else begin
            if (!too_long) begin
               line_length_in = line_length_ff + 1'b1;
            end
            if (started_ff || !q_info.is_ws) begin
               if (!started_ff) begin
                  started_in    = 1'b1;
                  first_char_in = q_info.rx_byte;
               end
               running_sum_in = running_sum_ff + q_info.rx_byte;
               if (q_info.is_space) begin
                  tent_valid_in = 1'b1;
                  tent_sum_in   = running_sum_in;
                  tent_two_in   = (token_index_ff >= 2'd2);
                  pending_ws_in = '0;
                  in_word_in    = 1'b0;
               end else if (q_info.is_ws) begin
                  if (pending_ws_ff != 4'hF) begin
                     pending_ws_in = pending_ws_ff + 1'b1;
                  end
                  in_word_in = 1'b0;
               end else begin
                  // commit the tentative separator
                  if (tent_valid_ff) begin
                     space_seen_in   = 1'b1;
                     sum_at_space_in = tent_sum_ff;
                     body_two_in     = tent_two_ff;
                     tok_value_in    = '0;
                     tok_chars_in    = '0;
                     tok_hex_ok_in   = 1'b1;
                     tent_valid_in   = 1'b0;
                  end
                  if (pending_ws_ff != '0) begin
                     char_sum      = {3'b000, tok_chars_in} + {1'b0, pending_ws_ff};
                     tok_hex_ok_in = 1'b0;
                     tok_chars_in  = (char_sum > 5'd3) ? 2'd3 : char_sum[1:0];
                  end
                  pending_ws_in = '0;
                  if (tok_chars_in != 2'd3) begin
                     tok_chars_in = tok_chars_in + 1'b1;
                  end
                  if (!q_info.is_hex || (tok_chars_in == 2'd3)) begin
                     tok_hex_ok_in = 1'b0;
                  end else begin
                     tok_value_in = {tok_value_in[3:0], q_info.hex_val};
                  end
                  if (word_start) begin
                     in_word_in = 1'b1;
                     if (token_index_ff != 2'd3) begin
                        token_index_in = token_index_ff + 1'b1;
                     end
                  end
                  if (token_index_in == 2'd2) begin
                     if (word_start && q_info.is_sign) begin
                        if (q_info.is_minus) begin
                           value_flags_in[VF_NEG_BIT] = 1'b1;
                        end
                     end else if (q_info.is_dec) begin
                        value_flags_in[VF_DIGIT_BIT] = 1'b1;
                        if (value_acc_ff <= MAG_LIMIT) begin
                           acc_cand = {value_acc_ff, 3'b000} + {2'b00, value_acc_ff, 1'b0}
                                      + {32'd0, q_info.hex_val};
                        end else begin
                           acc_cand = {3'b000, value_acc_ff};
                        end
                        if (acc_cand > {3'b000, MAG_LIMIT}) begin
                           value_flags_in[VF_BAD_BIT] = 1'b1;
                           value_acc_in = MAG_LIMIT + 33'd1;
                        end else begin
                           value_acc_in = acc_cand[32:0];
                        end
                     end else begin
                        value_flags_in[VF_BAD_BIT] = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_code_ff   <= res_code;
         out_sum_ff    <= res_sum;
         out_value_ff  <= $signed(res_value);
         out_dvalid_ff <= res_dvalid;
      end
      if (reset) begin
         out_valid_ff    <= 1'b0;
         line_length_ff  <= '0;
         running_sum_ff  <= '0;
         sum_at_space_ff <= '0;
         space_seen_ff   <= 1'b0;
         tok_value_ff    <= '0;
         tok_chars_ff    <= '0;
         tok_hex_ok_ff   <= 1'b1;
         pending_ws_ff   <= '0;
         first_char_ff   <= '0;
         token_index_ff  <= '0;
         value_acc_ff    <= '0;
         value_flags_ff  <= '0;
         started_ff      <= 1'b0;
         in_word_ff      <= 1'b0;
         tent_valid_ff   <= 1'b0;
         tent_sum_ff     <= '0;
         tent_two_ff     <= 1'b0;
         body_two_ff     <= 1'b0;
      end else begin
         if (in_ready) begin
            out_valid_ff <= emit;
         end
         line_length_ff  <= line_length_in;
         running_sum_ff  <= running_sum_in;
         sum_at_space_ff <= sum_at_space_in;
         space_seen_ff   <= space_seen_in;
         tok_value_ff    <= tok_value_in;
         tok_chars_ff    <= tok_chars_in;
         tok_hex_ok_ff   <= tok_hex_ok_in;
         pending_ws_ff   <= pending_ws_in;
         first_char_ff   <= first_char_in;
         token_index_ff  <= token_index_in;
         value_acc_ff    <= value_acc_in;
         value_flags_ff  <= value_flags_in;
         started_ff      <= started_in;
         in_word_ff      <= in_word_in;
         tent_valid_ff   <= tent_valid_in;
         tent_sum_ff     <= tent_sum_in;
         tent_two_ff     <= tent_two_in;
         body_two_ff     <= body_two_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.frame_code   = out_code_ff;
   assign rsp_chan.computed_sum = out_sum_ff;
   assign rsp_chan.data_value   = out_value_ff;
   assign rsp_chan.data_valid   = out_dvalid_ff;

   `ARFC_ASSERT_NEXT(a_no_result_mid_line, take && !q_info.is_cr && !out_valid_ff, !out_valid_ff)
   `ARFC_ASSERT_IMPL(a_data_only_on_ack, out_valid_ff && out_dvalid_ff, out_code_ff == FC_ACK)
   `ARFC_ASSERT_IMPL(a_zero_sum_no_body, out_valid_ff && (out_code_ff == FC_NO_SEP || out_code_ff == FC_TOO_LONG), out_sum_ff == 8'd0)
   `ARFC_ASSERT_IMPL(a_zero_value_invalid, out_valid_ff && !out_dvalid_ff, out_value_ff == 32'sd0)

endmodule
